// ----- hw/rtl/s256_pkg.sv -----
// SHA-256 stream hasher package: state codes, control structs, round constants.
// Used by every module of the hasher; depends on nothing.
`default_nettype none
package s256_pkg;

    localparam int unsigned BlkBytes = 64;
    localparam int unsigned BlkWords = BlkBytes / 4;
    localparam int unsigned Rounds   = 64;
    localparam int unsigned LenPos   = 56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WT
    } t_state;

    // How the block store formats the words of the block being compressed
    typedef struct packed {
        logic [6:0]  fill;   // stored bytes in front of the padding
        logic        pad;    // 0x80 marker at position fill
        logic        len;    // bit length in the last eight bytes
        logic [63:0] total;  // message bit length
    } t_blk_mode;

    // Commands from the sequencer to the round datapath
    typedef struct packed {
        logic       shift;   // shift hash word into the working registers
        logic       round;   // run one compression round
        logic [5:0] idx;     // round number
    } t_core_cmd;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        case (i)
            3'd0:    iv_word = 32'h6a09e667;
            3'd1:    iv_word = 32'hbb67ae85;
            3'd2:    iv_word = 32'h3c6ef372;
            3'd3:    iv_word = 32'ha54ff53a;
            3'd4:    iv_word = 32'h510e527f;
            3'd5:    iv_word = 32'h9b05688c;
            3'd6:    iv_word = 32'h1f83d9ab;
            default: iv_word = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] k_word(input logic [5:0] r);
        case (r)
            6'd0:  k_word = 32'h428a2f98; 6'd1:  k_word = 32'h71374491;
            6'd2:  k_word = 32'hb5c0fbcf; 6'd3:  k_word = 32'he9b5dba5;
            6'd4:  k_word = 32'h3956c25b; 6'd5:  k_word = 32'h59f111f1;
            6'd6:  k_word = 32'h923f82a4; 6'd7:  k_word = 32'hab1c5ed5;
            6'd8:  k_word = 32'hd807aa98; 6'd9:  k_word = 32'h12835b01;
            6'd10: k_word = 32'h243185be; 6'd11: k_word = 32'h550c7dc3;
            6'd12: k_word = 32'h72be5d74; 6'd13: k_word = 32'h80deb1fe;
            6'd14: k_word = 32'h9bdc06a7; 6'd15: k_word = 32'hc19bf174;
            6'd16: k_word = 32'he49b69c1; 6'd17: k_word = 32'hefbe4786;
            6'd18: k_word = 32'h0fc19dc6; 6'd19: k_word = 32'h240ca1cc;
            6'd20: k_word = 32'h2de92c6f; 6'd21: k_word = 32'h4a7484aa;
            6'd22: k_word = 32'h5cb0a9dc; 6'd23: k_word = 32'h76f988da;
            6'd24: k_word = 32'h983e5152; 6'd25: k_word = 32'ha831c66d;
            6'd26: k_word = 32'hb00327c8; 6'd27: k_word = 32'hbf597fc7;
            6'd28: k_word = 32'hc6e00bf3; 6'd29: k_word = 32'hd5a79147;
            6'd30: k_word = 32'h06ca6351; 6'd31: k_word = 32'h14292967;
            6'd32: k_word = 32'h27b70a85; 6'd33: k_word = 32'h2e1b2138;
            6'd34: k_word = 32'h4d2c6dfc; 6'd35: k_word = 32'h53380d13;
            6'd36: k_word = 32'h650a7354; 6'd37: k_word = 32'h766a0abb;
            6'd38: k_word = 32'h81c2c92e; 6'd39: k_word = 32'h92722c85;
            6'd40: k_word = 32'ha2bfe8a1; 6'd41: k_word = 32'ha81a664b;
            6'd42: k_word = 32'hc24b8b70; 6'd43: k_word = 32'hc76c51a3;
            6'd44: k_word = 32'hd192e819; 6'd45: k_word = 32'hd6990624;
            6'd46: k_word = 32'hf40e3585; 6'd47: k_word = 32'h106aa070;
            6'd48: k_word = 32'h19a4c116; 6'd49: k_word = 32'h1e376c08;
            6'd50: k_word = 32'h2748774c; 6'd51: k_word = 32'h34b0bcb5;
            6'd52: k_word = 32'h391c0cb3; 6'd53: k_word = 32'h4ed8aa4a;
            6'd54: k_word = 32'h5b9cca4f; 6'd55: k_word = 32'h682e6ff3;
            6'd56: k_word = 32'h748f82ee; 6'd57: k_word = 32'h78a5636f;
            6'd58: k_word = 32'h84c87814; 6'd59: k_word = 32'h8cc70208;
            6'd60: k_word = 32'h90befffa; 6'd61: k_word = 32'ha4506ceb;
            6'd62: k_word = 32'hbef9a3f7; default: k_word = 32'hc67178f2;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/s256_if.sv -----
// Stream interfaces of the SHA-256 hasher: byte input and digest output.
// Valid/ready handshake; depends on nothing.
`default_nettype none
interface s256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink (input valid, input data_byte, input byte_valid,
                  input end_of_message, output ready);
endinterface

interface s256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/s256_blkbuf.sv -----
// Block store: 16 x 32-bit memory with byte-lane writes and registered read,
// plus padding/length insertion on the read side. Uses s256_pkg.
`default_nettype none
module s256_blkbuf (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [5:0]           i_wr_pos,
    input  wire logic [7:0]           i_wr_byte,
    input  wire logic [3:0]           i_rd_addr,
    input  wire s256_pkg::t_blk_mode  i_mode,
    output logic [31:0]               o_word
);
    import s256_pkg::*;

    logic [31:0] r_mem [BlkWords];
    logic [31:0] r_rd_word;
    logic [3:0]  r_rd_addr;
    logic [5:0]  pos [4];

    // Write one byte lane, read one word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_pos[5:2]][{~i_wr_pos[1:0], 3'b000} +: 8] <= i_wr_byte;
        end
        r_rd_word <= r_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    // Replace bytes past the fill by the marker, zeros or the bit length
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pos[k] = {r_rd_addr, 2'(k)};
            if ({1'b0, pos[k]} < i_mode.fill) begin
                o_word[(3 - k) * 8 +: 8] = r_rd_word[(3 - k) * 8 +: 8];
            end else if (i_mode.pad && ({1'b0, pos[k]} == i_mode.fill)) begin
                o_word[(3 - k) * 8 +: 8] = 8'h80;
            end else if (i_mode.len && (pos[k] >= 6'(LenPos))) begin
                o_word[(3 - k) * 8 +: 8] = i_mode.total[{~pos[k][2:0], 3'b000} +: 8];
            end else begin
                o_word[(3 - k) * 8 +: 8] = 8'h00;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/s256_hmem.sv -----
// Hash word memory: 8 x 32 with registered read; reads the initial hash
// values while the fresh flag is set. Uses s256_pkg.
`default_nettype none
module s256_hmem (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr_en,
    input  wire logic [2:0]  i_wr_addr,
    input  wire logic [31:0] i_wr_data,
    input  wire logic [2:0]  i_rd_addr,
    input  wire logic        i_fresh_set,
    input  wire logic        i_fresh_clr,
    output logic [31:0]      o_rd_data
);
    import s256_pkg::*;

    logic [31:0] r_mem [8];
    logic        r_fresh;

    // Track whether the memory still stands for the initial values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= 1'b1;
        end else if (i_fresh_set) begin
            r_fresh <= 1'b1;
        end else if (i_fresh_clr) begin
            r_fresh <= 1'b0;
        end
    end

    // Write back and read one word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_fresh ? iv_word(i_rd_addr) : r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/s256_core.sv -----
// Round datapath: working registers a..h and the rolling 16-word schedule
// window, one round per cycle. Uses s256_pkg.
`default_nettype none
module s256_core (
    input  wire logic                i_clk,
    input  wire s256_pkg::t_core_cmd i_cmd,
    input  wire logic [31:0]         i_hash_word,
    input  wire logic [31:0]         i_blk_word,
    output logic [31:0]              o_head
);
    import s256_pkg::*;

    logic [31:0] r_v [8];
    logic [31:0] r_w [BlkWords];
    logic [31:0] w_cur, s0, s1, t1, t2, sig_e, sig_a, ch, maj;

    // Schedule word and round sums
    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_cur = (i_cmd.idx < 6'(BlkWords)) ? i_blk_word : (r_w[0] + s0 + r_w[9] + s1);
        sig_e = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        sig_a = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + sig_e + ch + k_word(i_cmd.idx) + w_cur;
        t2    = sig_a + maj;
    end

    // Shift in hash words, or advance one round
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            for (int i = 0; i < 7; i++) r_v[i] <= r_v[i + 1];
            r_v[7] <= i_hash_word;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < BlkWords - 1; i++) r_w[i] <= r_w[i + 1];
            r_w[BlkWords - 1] <= w_cur;
        end
    end

    assign o_head = r_v[0];
endmodule
`default_nettype wire

// ----- hw/rtl/sha256_stream_hasher_top.sv -----
// SHA-256 stream hasher top level: sequencer over block store, hash memory
// and round datapath. Uses s256_pkg, s256_if, s256_blkbuf, s256_hmem, s256_core.
//
//  channel  dir  handshake      beat payload
//  i_in     in   valid/ready    data_byte, byte_valid, end_of_message
//  o_out    out  valid/ready    digest_word, word_index, last_word
//
// A beat without a full block or end of message is taken while idle, and the
// sequencer stays idle. Each 64-byte block loads the hash memory into the working
// registers, runs 64 rounds, then adds and writes back; input is held off meanwhile.
// End of message runs one or two blocks, then each digest word is read, loaded
// and held until taken. Reset is synchronous and restarts the message.
`default_nettype none
module sha256_stream_hasher_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    s256_in_if.sink   i_in,
    s256_out_if.source o_out
);
    import s256_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_ctr;
    logic [5:0]  r_cnt;
    logic [63:0] r_bits;
    logic        r_eom_pend, r_final, r_second;
    t_blk_mode   r_mode;
    logic [2:0]  r_oidx;
    logic        r_ovalid;
    logic [31:0] r_odata;

    logic        acc, full;
    logic [6:0]  cnt_new;
    logic [5:0]  fin_c;
    logic [63:0] fin_total;

    logic        blk_wr;
    logic [3:0]  blk_raddr;
    logic [31:0] blk_word;
    logic        h_wr, fresh_set, fresh_clr;
    logic [2:0]  h_waddr, h_raddr;
    logic [31:0] h_rdata, head;
    t_core_cmd   cmd;

    assign acc     = i_in.valid && i_in.ready;
    assign cnt_new = {1'b0, r_cnt} + {6'd0, i_in.byte_valid};
    assign full    = cnt_new[6];
    assign fin_c   = (r_state == ST_IDLE) ? cnt_new[5:0] : 6'd0;
    assign fin_total = r_bits + {55'd0, fin_c, 3'b000};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (acc && (full || i_in.end_of_message)) n_state = ST_LOAD;
            ST_LOAD:   if (r_ctr == 6'd8) n_state = ST_ROUND;
            ST_ROUND:  if (r_ctr == 6'(Rounds - 1)) n_state = ST_ADD;
            ST_ADD: begin
                if (r_ctr == 6'd8) begin
                    if (r_final) n_state = ST_OUT_RD;
                    else if (r_second || r_eom_pend) n_state = ST_LOAD;
                    else n_state = ST_IDLE;
                end
            end
            ST_OUT_RD: n_state = ST_OUT_LD;
            ST_OUT_LD: n_state = ST_OUT_WT;
            ST_OUT_WT: begin
                if (o_out.ready) n_state = (r_oidx == 3'd7) ? ST_IDLE : ST_OUT_RD;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
        blk_wr     = acc && i_in.byte_valid;
        blk_raddr  = (r_state == ST_ROUND) ? (r_ctr[3:0] + 4'd1) : 4'd0;
        h_raddr    = (r_state == ST_OUT_RD) ? r_oidx : r_ctr[2:0];
        h_wr       = (r_state == ST_ADD) && (r_ctr != 6'd0);
        h_waddr    = r_ctr[2:0] - 3'd1;
        fresh_clr  = (r_state == ST_ADD) && (r_ctr == 6'd8);
        fresh_set  = (r_state == ST_OUT_WT) && o_out.ready && (r_oidx == 3'd7);
        cmd.shift  = ((r_state == ST_LOAD) || (r_state == ST_ADD)) && (r_ctr != 6'd0);
        cmd.round  = (r_state == ST_ROUND);
        cmd.idx    = r_ctr;
    end

    // Advance state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ctr   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_ctr   <= (n_state != r_state) ? 6'd0 : (r_ctr + 6'd1);
        end
    end

    // Track fill, bit count and the layout of the next block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= 6'd0;
            r_bits     <= 64'd0;
            r_eom_pend <= 1'b0;
            r_final    <= 1'b0;
            r_second   <= 1'b0;
        end else begin
            if (r_state == ST_IDLE && acc) begin
                if (full) begin
                    r_cnt       <= 6'd0;
                    r_bits      <= r_bits + 64'd512;
                    r_mode.fill <= 7'(BlkBytes);
                    r_mode.pad  <= 1'b0;
                    r_mode.len  <= 1'b0;
                    r_final     <= 1'b0;
                    r_second    <= 1'b0;
                    r_eom_pend  <= i_in.end_of_message;
                end else if (i_in.end_of_message) begin
                    r_cnt        <= 6'd0;
                    r_mode.fill  <= {1'b0, fin_c};
                    r_mode.pad   <= 1'b1;
                    r_mode.total <= fin_total;
                    r_mode.len   <= (fin_c < 6'(LenPos));
                    r_final      <= (fin_c < 6'(LenPos));
                    r_second     <= (fin_c >= 6'(LenPos));
                end else begin
                    r_cnt <= cnt_new[5:0];
                end
            end
            if (r_state == ST_ADD && r_ctr == 6'd8 && !r_final) begin
                if (r_second) begin
                    r_mode.fill <= 7'd0;
                    r_mode.pad  <= 1'b0;
                    r_mode.len  <= 1'b1;
                    r_final     <= 1'b1;
                    r_second    <= 1'b0;
                end else if (r_eom_pend) begin
                    r_mode.fill  <= 7'd0;
                    r_mode.pad   <= 1'b1;
                    r_mode.len   <= 1'b1;
                    r_mode.total <= fin_total;
                    r_final      <= 1'b1;
                    r_eom_pend   <= 1'b0;
                end
            end
            if (fresh_set) begin
                r_bits  <= 64'd0;
                r_final <= 1'b0;
            end
        end
    end

    // Hold the digest beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_oidx   <= 3'd0;
        end else if (r_state == ST_OUT_LD) begin
            r_ovalid <= 1'b1;
            r_odata  <= h_rdata;
        end else if (r_state == ST_OUT_WT && o_out.ready) begin
            r_ovalid <= 1'b0;
            r_oidx   <= r_oidx + 3'd1;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.digest_word = r_odata;
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 3'd7);

    s256_blkbuf u_blkbuf (
        .i_clk     (i_clk),
        .i_wr_en   (blk_wr),
        .i_wr_pos  (r_cnt),
        .i_wr_byte (i_in.data_byte),
        .i_rd_addr (blk_raddr),
        .i_mode    (r_mode),
        .o_word    (blk_word)
    );

    s256_hmem u_hmem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (h_wr),
        .i_wr_addr   (h_waddr),
        .i_wr_data   (h_rdata + head),
        .i_rd_addr   (h_raddr),
        .i_fresh_set (fresh_set),
        .i_fresh_clr (fresh_clr),
        .o_rd_data   (h_rdata)
    );

    s256_core u_core (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_hash_word (h_rdata),
        .i_blk_word  (blk_word),
        .o_head      (head)
    );
endmodule
`default_nettype wire
